FILE: rtl/core/brpc_pkg.sv
package brpc_pkg;

  localparam int K_W          = 12;
  localparam int N_W          = 13;
  localparam int SIDE_W       = 11;
  localparam int COORD_W      = 10;
  localparam int PHASE_W      = 16;
  localparam int DIV_STEPS    = 28;
  localparam int CS_W         = 20;
  localparam int Z_W          = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_X0    = 39797;
  localparam int PHASE_TO_RAD = 25736;
  localparam int COORD_MAX    = 1023;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_BUCKETS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [SIDE_W-1:0]  wm1;
    logic [SIDE_W-1:0]  hm1;
    logic [COORD_W-1:0] xtop;
    logic [COORD_W-1:0] ytop;
  } geom_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      4'd0:  v = 32'sd210828714;
      4'd1:  v = 32'sd124459457;
      4'd2:  v = 32'sd65760959;
      4'd3:  v = 32'sd33381290;
      4'd4:  v = 32'sd16755422;
      4'd5:  v = 32'sd8385879;
      4'd6:  v = 32'sd4193963;
      4'd7:  v = 32'sd2097109;
      4'd8:  v = 32'sd1048571;
      4'd9:  v = 32'sd524287;
      4'd10: v = 32'sd262144;
      4'd11: v = 32'sd131072;
      4'd12: v = 32'sd65536;
      4'd13: v = 32'sd32768;
      4'd14: v = 32'sd16384;
      default: v = 32'sd8192;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/brpc_phase_div.sv
module brpc_phase_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [brpc_pkg::K_W-1:0]         k_i,
  input  brpc_pkg::point_t                 pt_i,
  input  logic [brpc_pkg::N_W-1:0]         n_i,
  output logic                             valid_o,
  output logic [brpc_pkg::PHASE_W-1:0]     phase_o,
  output brpc_pkg::point_t                 pt_o
);
  import brpc_pkg::*;

  logic [DIV_STEPS-1:0] vld_q;
  logic [N_W-1:0]       rem_q [DIV_STEPS];
  logic [N_W-1:0]       rem_d [DIV_STEPS];
  logic [K_W-1:0]       k_q   [DIV_STEPS];
  logic [K_W-1:0]       k_d   [DIV_STEPS];
  logic [PHASE_W-1:0]   quo_q [DIV_STEPS];
  logic [PHASE_W-1:0]   quo_d [DIV_STEPS];
  point_t               pt_q  [DIV_STEPS];
  point_t               pt_d  [DIV_STEPS];

  always_comb begin
    logic [N_W-1:0]     prem;
    logic [K_W-1:0]     pk;
    logic [PHASE_W-1:0] pquo;
    logic [N_W:0]       t;
    logic               qb;
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        prem     = '0;
        pk       = k_i;
        pquo     = '0;
        pt_d[s]  = pt_i;
      end else begin
        prem     = rem_q[s-1];
        pk       = k_q[s-1];
        pquo     = quo_q[s-1];
        pt_d[s]  = pt_q[s-1];
      end
      t  = {prem, pk[K_W-1]};
      qb = (t >= {1'b0, n_i});
      if (qb) begin
        rem_d[s] = N_W'(t - {1'b0, n_i});
      end else begin
        rem_d[s] = t[N_W-1:0];
      end
      k_d[s]   = {pk[K_W-2:0], 1'b0};
      quo_d[s] = {pquo[PHASE_W-2:0], qb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        rem_q[s] <= rem_d[s];
        k_q[s]   <= k_d[s];
        quo_q[s] <= quo_d[s];
        pt_q[s]  <= pt_d[s];
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign phase_o = quo_q[DIV_STEPS-1];
  assign pt_o    = pt_q[DIV_STEPS-1];

endmodule

FILE: rtl/core/brpc_cordic.sv
module brpc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [brpc_pkg::PHASE_W-1:0]        phase_i,
  input  brpc_pkg::point_t                    pt_i,
  output logic                                valid_o,
  output logic [1:0]                          quad_o,
  output logic signed [brpc_pkg::CS_W-1:0]    cos_o,
  output logic signed [brpc_pkg::CS_W-1:0]    sin_o,
  output brpc_pkg::point_t                    pt_o
);
  import brpc_pkg::*;

  localparam int NST = CORDIC_STEPS + 1;

  logic [NST-1:0]        vld_q;
  logic signed [CS_W-1:0] x_q [NST];
  logic signed [CS_W-1:0] x_d [NST];
  logic signed [CS_W-1:0] y_q [NST];
  logic signed [CS_W-1:0] y_d [NST];
  logic signed [Z_W-1:0]  z_q [NST];
  logic signed [Z_W-1:0]  z_d [NST];
  logic [1:0]             q_q [NST];
  logic [1:0]             q_d [NST];
  point_t                 pt_q [NST];
  point_t                 pt_d [NST];

  always_comb begin
    logic signed [14:0]     r;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;
    r       = $signed({phase_i[13], phase_i[13:0]});
    q_d[0]  = phase_i[15:14] + {1'b0, phase_i[13]};
    x_d[0]  = CS_W'(CORDIC_X0);
    y_d[0]  = '0;
    z_d[0]  = Z_W'(Z_W'(r) * $signed(Z_W'(PHASE_TO_RAD)));
    pt_d[0] = pt_i;
    for (int s = 1; s < NST; s++) begin
      xs      = x_q[s-1] >>> (s - 1);
      ys      = y_q[s-1] >>> (s - 1);
      q_d[s]  = q_q[s-1];
      pt_d[s] = pt_q[s-1];
      if (!z_q[s-1][Z_W-1]) begin
        x_d[s] = x_q[s-1] - ys;
        y_d[s] = y_q[s-1] + xs;
        z_d[s] = z_q[s-1] - atan_lut(4'(s - 1));
      end else begin
        x_d[s] = x_q[s-1] + ys;
        y_d[s] = y_q[s-1] - xs;
        z_d[s] = z_q[s-1] + atan_lut(4'(s - 1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        x_q[s]  <= x_d[s];
        y_q[s]  <= y_d[s];
        z_q[s]  <= z_d[s];
        q_q[s]  <= q_d[s];
        pt_q[s] <= pt_d[s];
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quad_o  = q_q[NST-1];
  assign cos_o   = x_q[NST-1];
  assign sin_o   = y_q[NST-1];
  assign pt_o    = pt_q[NST-1];

endmodule

FILE: rtl/core/brpc_rotate.sv
module brpc_rotate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [1:0]                          quad_i,
  input  logic signed [brpc_pkg::CS_W-1:0]    cos_i,
  input  logic signed [brpc_pkg::CS_W-1:0]    sin_i,
  input  brpc_pkg::point_t                    pt_i,
  input  brpc_pkg::geom_t                     geom_i,
  output logic                                valid_o,
  output logic [brpc_pkg::COORD_W-1:0]        rx_o,
  output logic [brpc_pkg::COORD_W-1:0]        ry_o
);
  import brpc_pkg::*;

  localparam int D_W = SIDE_W + 2;
  localparam int P_W = D_W + CS_W;
  localparam int S_W = 35;

  logic [3:0] vld_q;

  logic signed [CS_W-1:0] co_q, si_q, co_d, si_d;
  logic signed [D_W-1:0]  dx_q, dy_q, dx_d, dy_d;
  logic signed [P_W-1:0]  pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [S_W-1:0]  xs_q, ys_q, xs_d, ys_d;
  logic [COORD_W-1:0]     rx_q, ry_q;

  function automatic logic [COORD_W-1:0] round_clamp(input logic signed [S_W-1:0] v,
                                                     input logic [COORD_W-1:0] top);
    logic [S_W-1:0] t;
    logic [COORD_W-1:0] r;
    t = (v + S_W'(65536)) >> 17;
    if (v[S_W-1]) begin
      r = '0;
    end else if (t > S_W'(top)) begin
      r = top;
    end else begin
      r = t[COORD_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    unique case (quad_i)
      2'd0: begin co_d = cos_i;  si_d = sin_i;  end
      2'd1: begin co_d = -sin_i; si_d = cos_i;  end
      2'd2: begin co_d = -cos_i; si_d = -sin_i; end
      default: begin co_d = sin_i; si_d = -cos_i; end
    endcase
    dx_d = $signed({2'b0, pt_i.x, 1'b0}) - $signed({2'b0, geom_i.wm1});
    dy_d = $signed({2'b0, geom_i.hm1}) - $signed({2'b0, pt_i.y, 1'b0});
    xs_d = S_W'(pxc_q) - S_W'(pys_q) + $signed({8'b0, geom_i.wm1, 16'b0});
    ys_d = $signed({8'b0, geom_i.hm1, 16'b0}) - (S_W'(pxs_q) + S_W'(pyc_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      co_q  <= co_d;
      si_q  <= si_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      pxc_q <= P_W'(P_W'(dx_q) * P_W'(co_q));
      pys_q <= P_W'(P_W'(dy_q) * P_W'(si_q));
      pxs_q <= P_W'(P_W'(dx_q) * P_W'(si_q));
      pyc_q <= P_W'(P_W'(dy_q) * P_W'(co_q));
      xs_q  <= xs_d;
      ys_q  <= ys_d;
      rx_q  <= round_clamp(xs_q, geom_i.xtop);
      ry_q  <= round_clamp(ys_q, geom_i.ytop);
    end
  end

  assign valid_o = vld_q[3];
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;

endmodule

FILE: rtl/core/bucketed_point_rotate_clamp_unit.sv
// Throughput: one beat per cycle while the output is not stalled; the
// 28-stage phase divider, the 17-stage CORDIC and the 4-stage rotate/clamp
// pipeline all advance together. A stalled output freezes the whole pipeline;
// input tready follows it. Reset (rst_ni low, asynchronous) empties the
// pipeline and loads width, height and bucket count with 32.
module bucketed_point_rotate_clamp_unit #(
  parameter int unsigned MAX_SIDE    = 1024,
  parameter int unsigned MAX_BUCKETS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], bucket_index[31:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // rotated_x[9:0], rotated_y[19:10], zero[23:20]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import brpc_pkg::*;

  logic [SIDE_W-1:0] width_q, height_q;
  logic [N_W-1:0]    buckets_q;

  logic              en;
  point_t            pt_in, pt_div, pt_cor;
  geom_t             geom;
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [N_W-1:0]    n_eff;
  logic              div_vld, cor_vld, out_vld;
  logic [PHASE_W-1:0] phase;
  logic [1:0]        quad;
  logic signed [CS_W-1:0] cos_v, sin_v;
  logic [COORD_W-1:0] rx, ry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SIDE_W'(32);
      height_q  <= SIDE_W'(32);
      buckets_q <= N_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:   width_q   <= cfg_data_i[SIDE_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_data_i[SIDE_W-1:0];
        REG_BUCKETS: buckets_q <= cfg_data_i[N_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = SIDE_W'(1);
    end else if (32'(width_q) > MAX_SIDE) begin
      w_eff = SIDE_W'(MAX_SIDE);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = SIDE_W'(1);
    end else if (32'(height_q) > MAX_SIDE) begin
      h_eff = SIDE_W'(MAX_SIDE);
    end else begin
      h_eff = height_q;
    end
    if (buckets_q == '0) begin
      n_eff = N_W'(1);
    end else if (32'(buckets_q) > MAX_BUCKETS) begin
      n_eff = N_W'(MAX_BUCKETS);
    end else begin
      n_eff = buckets_q;
    end
    geom.wm1  = w_eff - SIDE_W'(1);
    geom.hm1  = h_eff - SIDE_W'(1);
    geom.xtop = (geom.wm1 > SIDE_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : geom.wm1[COORD_W-1:0];
    geom.ytop = (geom.hm1 > SIDE_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : geom.hm1[COORD_W-1:0];
  end

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;
  assign pt_in.x       = s_axis_tdata[9:0];
  assign pt_in.y       = s_axis_tdata[19:10];

  brpc_phase_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .k_i     (s_axis_tdata[31:20]),
    .pt_i    (pt_in),
    .n_i     (n_eff),
    .valid_o (div_vld),
    .phase_o (phase),
    .pt_o    (pt_div)
  );

  brpc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .phase_i (phase),
    .pt_i    (pt_div),
    .valid_o (cor_vld),
    .quad_o  (quad),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .pt_o    (pt_cor)
  );

  brpc_rotate u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cor_vld),
    .quad_i  (quad),
    .cos_i   (cos_v),
    .sin_i   (sin_v),
    .pt_i    (pt_cor),
    .geom_i  (geom),
    .valid_o (out_vld),
    .rx_o    (rx),
    .ry_o    (ry)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {4'b0, ry, rx};

endmodule

FILE: rtl/core/brpc_chk.sv
module brpc_chk #(
  parameter int unsigned MAX_SIDE = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [12:0] cfg_data_i
);
  import brpc_pkg::*;

  logic [SIDE_W-1:0]  w_q, h_q;
  logic [COORD_W-1:0] xtop, ytop;

  function automatic logic [COORD_W-1:0] side_top(input logic [SIDE_W-1:0] s);
    logic [31:0] e;
    e = (s == '0) ? 32'd1 : ((32'(s) > MAX_SIDE) ? 32'(MAX_SIDE) : 32'(s));
    e = e - 32'd1;
    return (e > 32'(COORD_MAX)) ? COORD_W'(COORD_MAX) : e[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= SIDE_W'(32);
      h_q <= SIDE_W'(32);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) begin
        w_q <= cfg_data_i[SIDE_W-1:0];
      end
      if (cfg_idx_i == REG_HEIGHT) begin
        h_q <= cfg_data_i[SIDE_W-1:0];
      end
    end
  end

  assign xtop = side_top(w_q);
  assign ytop = side_top(h_q);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output beat right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:0] <= xtop)
    else $error("rotated_x beyond template width");

  a_y_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:10] <= ytop)
    else $error("rotated_y beyond template height");

endmodule

bind bucketed_point_rotate_clamp_unit brpc_chk #(.MAX_SIDE(MAX_SIDE)) u_brpc_chk (.*);

FILE: sim/tb_bucketed_point_rotate_clamp_unit.sv
module tb_bucketed_point_rotate_clamp_unit;
  import brpc_pkg::*;

  localparam int LATENCY = 49;

  typedef struct {
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
  } rot_point_t;

  class rotation_scoreboard;
    rot_point_t pending[$];
    int         errors;
    longint     width_reg, height_reg, buckets_reg;

    function new();
      errors      = 0;
      width_reg   = 32;
      height_reg  = 32;
      buckets_reg = 32;
    endfunction

    function void write_reg(reg_idx_e idx, longint val);
      case (idx)
        REG_WIDTH:   width_reg   = val & 'h7FF;
        REG_HEIGHT:  height_reg  = val & 'h7FF;
        REG_BUCKETS: buckets_reg = val & 'h1FFF;
        default: ;
      endcase
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint round_pix(longint v);
      if (v >= 0) return (v + 65536) >>> 17;
      return -((-v + 65536) >>> 17);
    endfunction

    function longint side_of(longint raw);
      if (raw < 1) return 1;
      if (raw > 1024) return 1024;
      return raw;
    endfunction

    function logic [COORD_W-1:0] clamp_pix(longint v, longint side);
      longint top;
      top = side - 1;
      if (top > COORD_MAX) top = COORD_MAX;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v[COORD_W-1:0];
    endfunction

    function void note_input(logic [9:0] px, logic [9:0] py, logic [11:0] k);
      longint w, h, n, r, x, y, z, xs, ys, c, s, co, si, dx, dy, rxq, ryq;
      logic [15:0] phase;
      int q;
      rot_point_t p;
      w = side_of(width_reg);
      h = side_of(height_reg);
      n = buckets_reg;
      if (n < 1) n = 1;
      if (n > 4096) n = 4096;
      phase = ((longint'(k) << 16) / n) & 'hFFFF;
      q = phase[15:14];
      r = phase[13:0];
      if (r >= 8192) begin
        q = (q + 1) & 3;
        r = r - 16384;
      end
      z = r * PHASE_TO_RAD;
      x = CORDIC_X0;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = fshift(x, i);
        ys = fshift(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_lut(4'(i));
        end else begin
          x += ys; y -= xs; z += atan_lut(4'(i));
        end
      end
      c = x;
      s = y;
      case (q)
        0: begin co = c;  si = s;  end
        1: begin co = -s; si = c;  end
        2: begin co = -c; si = -s; end
        default: begin co = s; si = -c; end
      endcase
      dx = 2 * longint'(px) - (w - 1);
      dy = (h - 1) - 2 * longint'(py);
      rxq = dx * co - dy * si + (w - 1) * 65536;
      ryq = (h - 1) * 65536 - (dx * si + dy * co);
      p.rx = clamp_pix(round_pix(rxq), w);
      p.ry = clamp_pix(round_pix(ryq), h);
      pending = {pending, p};
    endfunction

    function void check_result(logic [23:0] d);
      rot_point_t p;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      p = pending.pop_front();
      if (d[9:0] !== p.rx) begin
        $display("%0t: rotated_x expected %0d actual %0d", $time, p.rx, d[9:0]);
        errors++;
      end
      if (d[19:10] !== p.ry) begin
        $display("%0t: rotated_y expected %0d actual %0d", $time, p.ry, d[19:10]);
        errors++;
      end
      if (d[23:20] !== 4'd0) begin
        $display("%0t: pad expected 0 actual %h", $time, d[23:20]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  rotation_scoreboard sb = new();
  bit hold_off = 1'b0;
  bit random_stall = 1'b1;

  bucketed_point_rotate_clamp_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic write_cfg(reg_idx_e idx, logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(logic [9:0] px, logic [9:0] py, logic [11:0] k, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {k, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(px, py, k);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic random_points(int count, int max_gap);
    for (int i = 0; i < count; i++)
      send_point(10'($urandom), 10'($urandom), 12'($urandom),
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    int wait_cnt;
    wait_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (!random_stall) m_axis_tready <= 1'b1;
      else if (wait_cnt > 0) begin
        wait_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tvalid && m_axis_tready) wait_cnt = $urandom_range(0, 19);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [12:0] widths[4];
    logic [12:0] heights[4];
    logic [12:0] nbuck[4];
    widths  = '{13'd1, 13'd1024, 13'd0, 13'd2047};
    heights = '{13'd1024, 13'd1, 13'd2000, 13'd0};
    nbuck   = '{13'd4096, 13'd1, 13'd0, 13'd8191};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default geometry, edge cases
    send_point(0, 0, 0, 0);
    send_point(31, 31, 8, 0);
    send_point(1023, 1023, 16, 1);
    send_point(0, 1023, 24, 0);
    send_point(15, 16, 31, 2);
    send_point(5, 7, 4095, 0);
    send_point(1023, 0, 32, 0);
    send_point(16, 16, 100, 0);
    drain();

    write_cfg(REG_WIDTH, 1024);
    write_cfg(REG_HEIGHT, 1024);
    write_cfg(REG_BUCKETS, 4096);
    send_point(0, 0, 512, 0);
    send_point(1023, 1023, 1024, 0);
    send_point(512, 300, 4095, 0);
    send_point(700, 200, 2048, 0);
    random_points(100, 19);

    // long receiver hold-off while the sender keeps offering beats
    hold_off = 1'b1;
    fork
      random_points(80, 0);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();

    for (int j = 0; j < 4; j++) begin
      write_cfg(REG_WIDTH, widths[j]);
      write_cfg(REG_HEIGHT, heights[j]);
      write_cfg(REG_BUCKETS, nbuck[j]);
      if (j == 2) random_stall = 1'b0;
      random_points(40, 19);
      random_stall = 1'b1;
      drain();
    end

    write_cfg(REG_WIDTH, 13'($urandom_range(1, 1024)));
    write_cfg(REG_HEIGHT, 13'($urandom_range(1, 1024)));
    write_cfg(REG_BUCKETS, 13'($urandom_range(1, 4096)));
    random_points(60, 19);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
